// File: rtl/box_overlap_with_circle_prefilter_macros.svh
// assertion macros for the box overlap block
`ifndef BOX_OVERLAP_WITH_CIRCLE_PREFILTER_MACROS_SVH
`define BOX_OVERLAP_WITH_CIRCLE_PREFILTER_MACROS_SVH

// checked only outside reset
`define BOCP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define BOCP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bocp_pkg.sv
// shared constants for the box overlap block
`timescale 1ns / 1ps
`default_nettype none

package bocp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

endpackage

`default_nettype wire

// File: rtl/bocp_chan_if.sv
// request and response channel interfaces for the box overlap block
`timescale 1ns / 1ps
`default_nettype none

interface bocp_req_if #(
  parameter int COORD_WIDTH = bocp_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_pos_x;
  logic signed [COORD_WIDTH-1:0] first_pos_y;
  logic        [COORD_WIDTH-2:0] first_width;
  logic        [COORD_WIDTH-2:0] first_height;
  logic signed [COORD_WIDTH-1:0] first_center_x;
  logic signed [COORD_WIDTH-1:0] first_center_y;
  logic signed [COORD_WIDTH-1:0] second_pos_x;
  logic signed [COORD_WIDTH-1:0] second_pos_y;
  logic        [COORD_WIDTH-2:0] second_width;
  logic        [COORD_WIDTH-2:0] second_height;
  logic signed [COORD_WIDTH-1:0] second_center_x;
  logic signed [COORD_WIDTH-1:0] second_center_y;

  modport source (
    output valid, first_pos_x, first_pos_y, first_width, first_height,
           first_center_x, first_center_y, second_pos_x, second_pos_y,
           second_width, second_height, second_center_x, second_center_y,
    input  ready
  );

  modport sink (
    input  valid, first_pos_x, first_pos_y, first_width, first_height,
           first_center_x, first_center_y, second_pos_x, second_pos_y,
           second_width, second_height, second_center_x, second_center_y,
    output ready
  );
endinterface

interface bocp_rsp_if ();
  logic valid;
  logic ready;
  logic circle_hit;
  logic box_hit;

  modport source (output valid, circle_hit, box_hit, input ready);
  modport sink (input valid, circle_hit, box_hit, output ready);
endinterface

`default_nettype wire

// File: rtl/bocp_front.sv
// front pipeline: centre distance, diagonals, axis overlap and the circle difference term
`timescale 1ns / 1ps
`default_nettype none

module bocp_front #(
  parameter int COORD_WIDTH = bocp_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  bocp_req_if.sink req,
  output logic q_valid,
  input  logic q_ready,
  output logic [2+2*(2*COORD_WIDTH+3)/2+2*(2*COORD_WIDTH-1)-1:0] q_data
);
  localparam int W  = COORD_WIDTH;
  localparam int SW = COORD_WIDTH - 1;
  localparam int DW = 2 * COORD_WIDTH + 3;
  localparam int AW = 2 * COORD_WIDTH - 1;

  logic adv;

  // stage 1: centre distances and axis tests
  logic          s1_valid;
  logic [W-1:0]  s1_dx, s1_dy;
  logic [SW-1:0] s1_w1, s1_h1, s1_w2, s1_h2;
  logic          s1_axis;

  logic signed [W:0] cdx, cdy, cdx_neg, cdy_neg;
  logic [W-1:0]      dx, dy;
  logic signed [W:0] p1x, p1y, p2x, p2y, w1e, h1e, w2e, h2e;
  logic              axis_ok;

  always_comb begin
    cdx = $signed({req.first_center_x[W-1], req.first_center_x})
        - $signed({req.second_center_x[W-1], req.second_center_x});
    cdy = $signed({req.first_center_y[W-1], req.first_center_y})
        - $signed({req.second_center_y[W-1], req.second_center_y});
    cdx_neg = -cdx;
    cdy_neg = -cdy;
    dx = cdx[W] ? cdx_neg[W-1:0] : cdx[W-1:0];
    dy = cdy[W] ? cdy_neg[W-1:0] : cdy[W-1:0];

    p1x = $signed({req.first_pos_x[W-1], req.first_pos_x});
    p1y = $signed({req.first_pos_y[W-1], req.first_pos_y});
    p2x = $signed({req.second_pos_x[W-1], req.second_pos_x});
    p2y = $signed({req.second_pos_y[W-1], req.second_pos_y});
    w1e = $signed({2'b00, req.first_width});
    h1e = $signed({2'b00, req.first_height});
    w2e = $signed({2'b00, req.second_width});
    h2e = $signed({2'b00, req.second_height});

    // strict overlap, touching edges do not count
    axis_ok = (p1x < p2x + w2e) && (p1y < p2y + h2e)
           && (p1x + w1e > p2x) && (p1y + h1e > p2y);
  end

  // stage 2: squares
  logic            s2_valid;
  logic [2*W-1:0]  s2_dx2, s2_dy2;
  logic [2*SW-1:0] s2_w1sq, s2_h1sq, s2_w2sq, s2_h2sq;
  logic            s2_axis;

  // stage 3: sums
  logic          s3_valid;
  logic [DW-1:0] s3_four_l;
  logic [AW-1:0] s3_a, s3_b;
  logic [2*W-1:0] s3_ab;
  logic          s3_axis;

  logic [2*W:0] l_sum;
  assign l_sum = {1'b0, s2_dx2} + {1'b0, s2_dy2};

  // stage 4: difference term and its sign
  logic          s4_valid;
  logic          s4_neg;
  logic [DW-1:0] s4_d;
  logic [AW-1:0] s4_a, s4_b;
  logic          s4_axis;

  assign adv       = !s4_valid || q_ready;
  assign req.ready = adv;
  assign q_valid   = s4_valid;
  assign q_data    = {s4_axis, s4_neg, s4_d, s4_a, s4_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx   <= dx;
      s1_dy   <= dy;
      s1_w1   <= req.first_width;
      s1_h1   <= req.first_height;
      s1_w2   <= req.second_width;
      s1_h2   <= req.second_height;
      s1_axis <= axis_ok;

      s2_dx2  <= s1_dx * s1_dx;
      s2_dy2  <= s1_dy * s1_dy;
      s2_w1sq <= s1_w1 * s1_w1;
      s2_h1sq <= s1_h1 * s1_h1;
      s2_w2sq <= s1_w2 * s1_w2;
      s2_h2sq <= s1_h2 * s1_h2;
      s2_axis <= s1_axis;

      s3_four_l <= {l_sum, 2'b00};
      s3_a      <= {1'b0, s2_w1sq} + {1'b0, s2_h1sq};
      s3_b      <= {1'b0, s2_w2sq} + {1'b0, s2_h2sq};
      s3_ab     <= {2'b00, s2_w1sq} + {2'b00, s2_h1sq}
                 + {2'b00, s2_w2sq} + {2'b00, s2_h2sq};
      s3_axis   <= s2_axis;

      s4_neg  <= s3_four_l < {3'b000, s3_ab};
      s4_d    <= s3_four_l - {3'b000, s3_ab};
      s4_a    <= s3_a;
      s4_b    <= s3_b;
      s4_axis <= s3_axis;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bocp_queue.sv
// small register queue between the front and back pipelines
`timescale 1ns / 1ps
`default_nettype none

module bocp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bocp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign in_ready  = count != CW'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bocp_back.sv
// back pipeline: split wide products and the final circle and box decision
`timescale 1ns / 1ps
`default_nettype none

module bocp_back #(
  parameter int COORD_WIDTH = bocp_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  logic [2+2*(2*COORD_WIDTH+3)/2+2*(2*COORD_WIDTH-1)-1:0] q_data,
  bocp_rsp_if.source rsp
);
  localparam int DW    = 2 * COORD_WIDTH + 3;
  localparam int AW    = 2 * COORD_WIDTH - 1;
  localparam int DL    = (DW + 1) / 2;
  localparam int DH    = DW - DL;
  localparam int AL    = (AW + 1) / 2;
  localparam int AH    = AW - AL;
  localparam int DSQ_W = 2 * DW;
  localparam int PW    = 2 * AW;
  localparam int AB4_W = 2 * AW + 2;

  logic          e_axis, e_neg;
  logic [DW-1:0] e_d;
  logic [AW-1:0] e_a, e_b;

  assign {e_axis, e_neg, e_d, e_a, e_b} = q_data;

  logic adv;
  assign adv     = !rsp.valid || rsp.ready;
  assign q_ready = adv;

  // stage 1: partial products, each operand at most half the word, rounded up
  logic             t1_valid;
  logic             t1_neg, t1_axis;
  logic [2*DL-1:0]  t1_dll;
  logic [DL+DH-1:0] t1_dlh;
  logic [2*DH-1:0]  t1_dhh;
  logic [2*AL-1:0]  t1_all;
  logic [AL+AH-1:0] t1_alh, t1_ahl;
  logic [2*AH-1:0]  t1_ahh;

  // stage 2: reassembled products
  logic             t2_valid;
  logic             t2_neg, t2_axis;
  logic [DSQ_W-1:0] t2_dsq;
  logic [AB4_W-1:0] t2_ab4;

  logic [DSQ_W-1:0] dsq;
  logic [PW-1:0]    prod;
  logic             circle;

  always_comb begin
    dsq  = {t1_dhh, t1_dll} + (DSQ_W'(t1_dlh) << (DL + 1));
    prod = {t1_ahh, t1_all} + (PW'(t1_alh) << AL) + (PW'(t1_ahl) << AL);
    // a negative difference already means the circles overlap
    circle = t2_neg || (t2_dsq < DSQ_W'(t2_ab4));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid  <= 1'b0;
      t2_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (adv) begin
      t1_valid  <= q_valid;
      t2_valid  <= t1_valid;
      rsp.valid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_neg  <= e_neg;
      t1_axis <= e_axis;
      t1_dll  <= e_d[DL-1:0] * e_d[DL-1:0];
      t1_dlh  <= e_d[DL-1:0] * e_d[DW-1:DL];
      t1_dhh  <= e_d[DW-1:DL] * e_d[DW-1:DL];
      t1_all  <= e_a[AL-1:0] * e_b[AL-1:0];
      t1_alh  <= e_a[AL-1:0] * e_b[AW-1:AL];
      t1_ahl  <= e_a[AW-1:AL] * e_b[AL-1:0];
      t1_ahh  <= e_a[AW-1:AL] * e_b[AW-1:AL];

      t2_neg  <= t1_neg;
      t2_axis <= t1_axis;
      t2_dsq  <= dsq;
      t2_ab4  <= {prod, 2'b00};

      rsp.circle_hit <= circle;
      rsp.box_hit    <= circle && t2_axis;
    end
  end

endmodule

`default_nettype wire

// File: rtl/box_overlap_with_circle_prefilter.sv
// Box overlap test with a bounding-circle prefilter.
//
// req carries one pair of boxes per beat (corner, size and centre of each,
// fixed point with four fraction bits, sizes unsigned, the rest signed);
// rsp returns one beat per pair with circle_hit and box_hit. Beats move on
// valid and ready both high.
// Throughput is one pair per cycle while rsp does not stall. The front
// pipeline has four stages and feeds a register queue of QUEUE_DEPTH
// entries; the back pipeline has three stages ending in the output register.
// A pair passes the front stages, the queue and the back stages in turn.
//
// When rsp stalls, the back pipeline holds and the queue fills; req keeps
// being taken until the last front stage holds a beat the full queue cannot
// take, then req.ready drops and the whole front pipeline holds.
// The front and back each advance as a whole, so a stall costs no results.
//
// Synchronous reset empties both pipelines and the queue; rsp.valid is low
// on the cycle after reset, and the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module box_overlap_with_circle_prefilter #(
  parameter int COORD_WIDTH = bocp_pkg::COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = bocp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  bocp_req_if.sink   req,
  bocp_rsp_if.source rsp
);
  localparam int QW = 2 + 2 * (2 * COORD_WIDTH + 3) / 2 + 2 * (2 * COORD_WIDTH - 1);

  logic          f_valid, f_ready;
  logic [QW-1:0] f_data;
  logic          b_valid, b_ready;
  logic [QW-1:0] b_data;

  bocp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_data  (f_data)
  );

  bocp_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  bocp_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_data  (b_data),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

// File: rtl/bocp_checker.sv
// port checks for the box overlap block and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "box_overlap_with_circle_prefilter_macros.svh"

module bocp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic circle_hit,
  input wire logic box_hit
);

  // a box hit needs the circle test to pass
  `BOCP_ASSERT(a_box_needs_circle, clk, rst, rsp_valid && box_hit |-> circle_hit, "box_hit without circle_hit")

  `BOCP_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> !rsp_valid, "rsp valid straight after reset")

  `BOCP_ASSERT(a_rsp_held, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "stalled rsp beat dropped")

  `BOCP_ASSERT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready |=> $stable(circle_hit) && $stable(box_hit), "stalled rsp beat changed")

endmodule

bind box_overlap_with_circle_prefilter bocp_checker u_bocp_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .circle_hit (rsp.circle_hit),
  .box_hit    (rsp.box_hit)
);

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for the box overlap block with circle prefilter
`timescale 1ns / 1ps

module tb;

  localparam int CW = bocp_pkg::COORD_WIDTH_DEF;
  localparam int RANDOM_PAIRS = 1900;
  localparam int CALM_FROM = 1500;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [CW-1:0] first_pos_x;
    logic signed [CW-1:0] first_pos_y;
    logic        [CW-2:0] first_width;
    logic        [CW-2:0] first_height;
    logic signed [CW-1:0] first_center_x;
    logic signed [CW-1:0] first_center_y;
    logic signed [CW-1:0] second_pos_x;
    logic signed [CW-1:0] second_pos_y;
    logic        [CW-2:0] second_width;
    logic        [CW-2:0] second_height;
    logic signed [CW-1:0] second_center_x;
    logic signed [CW-1:0] second_center_y;
  } box_pair_t;

  typedef struct packed {
    logic circle_hit;
    logic box_hit;
  } hit_pair_t;

  class hit_scoreboard;
    hit_pair_t expected_hits[$];
    int mismatches;
    int checked;
    int circle_count;
    int box_count;

    function new();
      mismatches = 0;
      checked = 0;
      circle_count = 0;
      box_count = 0;
    endfunction

    // exact bounding-circle test: 4L - A - B < 0, or else its square below 4AB
    function hit_pair_t predict_hits(box_pair_t p);
      longint dx, dy, four_l, diag_a, diag_b, excess;
      longint p1x, p1y, w1, h1, p2x, p2y, w2, h2;
      bit [127:0] excess_sq, diag_prod4;
      hit_pair_t r;
      p1x = p.first_pos_x;
      p1y = p.first_pos_y;
      w1 = p.first_width;
      h1 = p.first_height;
      p2x = p.second_pos_x;
      p2y = p.second_pos_y;
      w2 = p.second_width;
      h2 = p.second_height;
      dx = longint'(p.first_center_x) - longint'(p.second_center_x);
      dy = longint'(p.first_center_y) - longint'(p.second_center_y);
      four_l = 4 * (dx * dx + dy * dy);
      diag_a = w1 * w1 + h1 * h1;
      diag_b = w2 * w2 + h2 * h2;
      excess = four_l - diag_a - diag_b;
      if (excess < 0) begin
        r.circle_hit = 1'b1;
      end else begin
        excess_sq = 128'(excess) * 128'(excess);
        diag_prod4 = 128'(diag_a) * 128'(diag_b) * 128'(4);
        r.circle_hit = excess_sq < diag_prod4;
      end
      // touching edges do not count as overlap
      r.box_hit = r.circle_hit && (p1x < p2x + w2) && (p1y < p2y + h2) &&
                  (p1x + w1 > p2x) && (p1y + h1 > p2y);
      return r;
    endfunction

    function void note_pair(box_pair_t p);
      expected_hits.insert(expected_hits.size(), predict_hits(p));
    endfunction

    function void check_hits(logic circle_hit, logic box_hit);
      hit_pair_t want;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result beat with nothing expected: circle_hit %0b box_hit %0b",
                   circle_hit, box_hit);
        return;
      end
      want = expected_hits.pop_front();
      if (circle_hit !== want.circle_hit) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d: circle_hit %0b, expected %0b",
                   checked, circle_hit, want.circle_hit);
      end
      if (box_hit !== want.box_hit) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d: box_hit %0b, expected %0b", checked, box_hit, want.box_hit);
      end
      checked++;
      circle_count += want.circle_hit;
      box_count += want.box_hit;
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit idle_on;
  int pairs_sent;
  int cycle_count;
  hit_scoreboard hits_sb = new();
  box_pair_t directed[$];

  bocp_req_if #(.COORD_WIDTH(CW)) req_ch ();
  bocp_rsp_if rsp_ch ();

  box_overlap_with_circle_prefilter #(.COORD_WIDTH(CW)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic box_pair_t make_pair(int p1x, int p1y, int w1, int h1, int c1x, int c1y,
                                          int p2x, int p2y, int w2, int h2, int c2x,
                                          int c2y);
    box_pair_t p;
    p.first_pos_x = CW'(p1x);
    p.first_pos_y = CW'(p1y);
    p.first_width = (CW-1)'(w1);
    p.first_height = (CW-1)'(h1);
    p.first_center_x = CW'(c1x);
    p.first_center_y = CW'(c1y);
    p.second_pos_x = CW'(p2x);
    p.second_pos_y = CW'(p2y);
    p.second_width = (CW-1)'(w2);
    p.second_height = (CW-1)'(h2);
    p.second_center_x = CW'(c2x);
    p.second_center_y = CW'(c2y);
    return p;
  endfunction

  function automatic void add_directed(box_pair_t p);
    directed.insert(directed.size(), p);
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // mostly well-formed nearby boxes, with abutting edges, odd centres and noise mixed in
  function automatic box_pair_t random_pair();
    int kind, span, w1, h1, w2, h2, p1x, p1y, p2x, p2y, c1x, c1y, c2x, c2y;
    kind = $urandom_range(0, 99);
    if (kind < 15)
      return make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    span = (kind < 30) ? 48 : ((kind < 93) ? 2048 : 32767);
    w1 = $urandom_range(0, span);
    h1 = $urandom_range(0, span);
    w2 = $urandom_range(0, span);
    h2 = $urandom_range(0, span);
    p1x = (kind < 93) ? spread(16000) : spread(8000);
    p1y = (kind < 93) ? spread(16000) : spread(8000);
    p2x = p1x + spread(span + span / 2);
    p2y = p1y + spread(span + span / 2);
    if (kind >= 30 && kind < 45) begin
      // edges that just touch on one axis
      if ($urandom_range(0, 1)) p2x = $urandom_range(0, 1) ? p1x + w1 : p1x - w2;
      else p2y = $urandom_range(0, 1) ? p1y + h1 : p1y - h2;
    end
    c1x = p1x + w1 / 2;
    c1y = p1y + h1 / 2;
    c2x = p2x + w2 / 2;
    c2y = p2y + h2 / 2;
    if (kind >= 85 && kind < 93) begin
      // centres placed away from their boxes
      c1x = p1x + spread(2 * span);
      c1y = p1y + spread(2 * span);
      c2x = p2x + spread(2 * span);
      c2y = p2y + spread(2 * span);
    end
    return make_pair(p1x, p1y, w1, h1, c1x, c1y, p2x, p2y, w2, h2, c2x, c2y);
  endfunction

  // called on a rising edge; returns on the edge that takes the beat
  task automatic send_pair(input box_pair_t p);
    req_ch.valid <= 1'b1;
    {req_ch.first_pos_x, req_ch.first_pos_y, req_ch.first_width, req_ch.first_height,
     req_ch.first_center_x, req_ch.first_center_y, req_ch.second_pos_x, req_ch.second_pos_y,
     req_ch.second_width, req_ch.second_height, req_ch.second_center_x,
     req_ch.second_center_y} <= p;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    hits_sb.note_pair(p);
    pairs_sent++;
  endtask

  task automatic await_drain();
    req_ch.valid <= 1'b0;
    while (hits_sb.pending() != 0) @(posedge clk);
  endtask

  // result side: check every beat taken, stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        hits_sb.check_hits(rsp_ch.circle_hit, rsp_ch.box_hit);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_count, hits_sb.pending());
    $display("** box_overlap_with_circle_prefilter: FAILED **");
    $finish;
  end

  initial begin
    idle_on = 1'b0;
    pairs_sent = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    {req_ch.first_pos_x, req_ch.first_pos_y, req_ch.first_width, req_ch.first_height,
     req_ch.first_center_x, req_ch.first_center_y, req_ch.second_pos_x, req_ch.second_pos_y,
     req_ch.second_width, req_ch.second_height, req_ch.second_center_x,
     req_ch.second_center_y} <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero-size boxes at the same centre
    add_directed(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // edges touching on x, then an overlapping pair
    add_directed(make_pair(0, 0, 16, 16, 8, 8, 16, 0, 16, 16, 24, 8));
    add_directed(make_pair(0, 0, 32, 32, 16, 16, 16, 16, 32, 32, 32, 32));
    // circles exactly touching, then just overlapping
    add_directed(make_pair(-24, -32, 48, 64, 0, 0, 24, 32, 48, 64, 48, 64));
    add_directed(make_pair(-24, -32, 48, 64, 0, 0, 24, 31, 48, 64, 48, 63));
    add_directed(make_pair(-24, -32, 48, 64, 0, 0, 23, 31, 48, 64, 48, 63));
    // opposite extremes of the coordinate range
    add_directed(make_pair(-32768, -32768, 32767, 32767, -32768, -32768,
                           32767, 32767, 32767, 32767, 32767, 32767));
    add_directed(make_pair(-16384, -16384, 32767, 32767, 0, 0,
                           -16384, -16384, 32767, 32767, 0, 0));
    add_directed(make_pair(32767, 32767, 32767, 32767, 0, 0,
                           -32768, -32768, 32767, 32767, 0, 0));
    // zero-width box inside another, and on its edge
    add_directed(make_pair(0, 0, 0, 32, 0, 16, -16, -16, 64, 64, 16, 16));
    add_directed(make_pair(48, 0, 0, 32, 48, 16, -16, -16, 64, 64, 16, 16));
    // centres that do not match their boxes
    add_directed(make_pair(0, 0, 16, 16, 500, 500, 1000, 1000, 16, 16, 500, 500));
    add_directed(make_pair(0, 0, 64, 64, -30000, 0, 0, 0, 64, 64, 30000, 0));
    add_directed(make_pair(-100, -100, 50, 50, -75, -75, -80, -80, 50, 50, -55, -55));
    add_directed(make_pair(0, 0, 1, 1, 0, 0, 0, 0, 1, 1, 0, 0));
    add_directed(make_pair(-1, -1, 32767, 32767, -1, -1, -1, -1, 32767, 32767, -1, -1));
    add_directed(make_pair(32767, 32767, 0, 0, 32767, 32767,
                           32767, 32767, 0, 0, 32767, 32767));
    add_directed(make_pair(-32768, -32768, 16384, 16384, -32768, -32768,
                           -32768, -32768, 16384, 16384, -32768, -32768));
    foreach (directed[i]) send_pair(directed[i]);

    // hold off until the pipeline is empty
    await_drain();

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 100 == 0) idle_on = (n < CALM_FROM) && ($urandom_range(0, 3) != 0);
      if (n == RANDOM_PAIRS / 2) await_drain();
      if (idle_on && $urandom_range(0, 5) == 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      send_pair(random_pair());
    end

    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d box pairs (directed edge cases, then random), %0d results checked",
             pairs_sent, hits_sb.checked);
    $display("circle hits %0d, box hits %0d, mismatches %0d",
             hits_sb.circle_count, hits_sb.box_count, hits_sb.mismatches);
    if (hits_sb.mismatches == 0 && hits_sb.pending() == 0) begin
      $display("** box_overlap_with_circle_prefilter: PASSED **");
    end else begin
      $display("** box_overlap_with_circle_prefilter: FAILED **");
    end
    $finish;
  end

endmodule
